// ----- rtl/pid_pkg.sv -----
// Shared widths, control word layout and microcode ROM for the PID step block.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package pid_pkg;

    // Block configuration
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int INTEGRAL_WIDTH = 40;

    // Fixed field widths
    localparam int GAIN_W    = 16;
    localparam int TICK_W    = 16;
    localparam int OUT_W     = 32;
    localparam int SAT_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Derived datapath widths
    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 2;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int LO_W   = INTEGRAL_WIDTH / 2;
    localparam int HI_W   = INTEGRAL_WIDTH - LO_W;
    localparam int MA_W   = TICK_W + 1;
    localparam int MB_W0  = (DIFF_W > LO_W + 1) ? DIFF_W : LO_W + 1;
    localparam int MB_W   = (MB_W0 > HI_W) ? MB_W0 : HI_W;
    localparam int MUL_W  = MA_W + MB_W;
    localparam int PRD_W  = GAIN_W + INTEGRAL_WIDTH + 1;
    localparam int SUM_W0 = (MUL_W > PRD_W) ? MUL_W : PRD_W;
    localparam int SUM_W  = ((SUM_W0 > SAT_W) ? SUM_W0 : SAT_W) + 1;
    localparam int INT_SUM_W = ((INTEGRAL_WIDTH > MUL_W) ? INTEGRAL_WIDTH : MUL_W) + 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);
    localparam int STEP_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    // Multiplier operand selects
    typedef enum logic [1:0] {A_TICKS, A_PROP, A_INTEG, A_DERIV} a_sel_t;
    typedef enum logic [1:0] {B_ERR, B_QUOT, B_ILO, B_IHI} b_sel_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INTEG,
        OP_TMP_LO,
        OP_TMP_HI,
        OP_ACC_LOAD,
        OP_ACC_MUL,
        OP_ACC_TMP,
        OP_EMIT
    } dp_op_t;

    // Sequencing of a control word
    typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_DIV, JMP_WAIT_OUT_END} jump_t;

    typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   mul_en;
        dp_op_t op;
        logic   div_start;
        jump_t  jmp;
    } ucode_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   mul_en;
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } seq_stat_t;

    // Microcode program for one step of the controller
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '{a_sel: A_TICKS, b_sel: B_ERR, mul_en: 1'b0, op: OP_NONE,
               div_start: 1'b0, jmp: JMP_NEXT};
        unique case (step)
            // error * ticks, launch the derivative divide
            STEP_W'(0): begin
                uc.mul_en    = 1'b1;
                uc.div_start = 1'b1;
            end
            // fold into the saturating integral
            STEP_W'(1): uc.op = OP_INTEG;
            // integral gain times low half of the integral
            STEP_W'(2): begin
                uc.a_sel  = A_INTEG;
                uc.b_sel  = B_ILO;
                uc.mul_en = 1'b1;
            end
            // integral gain times high half; keep the low product
            STEP_W'(3): begin
                uc.a_sel  = A_INTEG;
                uc.b_sel  = B_IHI;
                uc.mul_en = 1'b1;
                uc.op     = OP_TMP_LO;
            end
            // proportional product; merge the high integral product
            STEP_W'(4): begin
                uc.a_sel  = A_PROP;
                uc.b_sel  = B_ERR;
                uc.mul_en = 1'b1;
                uc.op     = OP_TMP_HI;
            end
            STEP_W'(5): uc.op = OP_ACC_LOAD;
            // hold until the quotient is ready
            STEP_W'(6): uc.jmp = JMP_WAIT_DIV;
            STEP_W'(7): begin
                uc.a_sel  = A_DERIV;
                uc.b_sel  = B_QUOT;
                uc.mul_en = 1'b1;
            end
            STEP_W'(8): uc.op = OP_ACC_MUL;
            STEP_W'(9): uc.op = OP_ACC_TMP;
            // publish once the output register is free, then stop
            STEP_W'(10): begin
                uc.op  = OP_EMIT;
                uc.jmp = JMP_WAIT_OUT_END;
            end
            default: uc.jmp = JMP_WAIT_OUT_END;
        endcase
        return uc;
    endfunction

endpackage

// ----- rtl/pid_seq.sv -----
// Microcode sequencer: step counter over the ROM in pid_pkg, with wait jumps.
// Depends on pid_pkg.
module pid_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pid_pkg::seq_stat_t  stat,
    output logic                busy,
    output logic                div_start,
    output pid_pkg::dp_ctrl_t   ctrl
);

    pid_pkg::seq_state_t            state_reg, state_next;
    logic [pid_pkg::STEP_W-1:0]     step_reg, step_next;
    pid_pkg::ucode_t                uc;
    logic                           hold;
    logic                           active;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pid_pkg::SEQ_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Decode the current word, gate it while waiting, advance
    always_comb
    begin
        uc = pid_pkg::ucode_rom(step_reg);
        unique case (uc.jmp)
            pid_pkg::JMP_WAIT_DIV:     hold = stat.div_busy;
            pid_pkg::JMP_WAIT_OUT_END: hold = stat.out_full;
            default:                   hold = 1'b0;
        endcase
        active = (state_reg == pid_pkg::SEQ_RUN) && !hold;

        ctrl.a_sel  = uc.a_sel;
        ctrl.b_sel  = uc.b_sel;
        ctrl.mul_en = uc.mul_en & active;
        ctrl.op     = active ? uc.op : pid_pkg::OP_NONE;
        div_start   = uc.div_start & active;
        busy        = (state_reg == pid_pkg::SEQ_RUN);

        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            pid_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = pid_pkg::SEQ_RUN;
                    step_next  = '0;
                end
            end
            pid_pkg::SEQ_RUN:
            begin
                if (!hold)
                begin
                    if (uc.jmp == pid_pkg::JMP_WAIT_OUT_END)
                    begin
                        state_next = pid_pkg::SEQ_IDLE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = pid_pkg::SEQ_IDLE;
                step_next  = '0;
            end
        endcase
    end

endmodule

// ----- rtl/pid_div.sv -----
// Bit-serial restoring divider for the error rate, truncating toward zero.
// Depends on pid_pkg for the operand widths.
module pid_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [pid_pkg::DIFF_W-1:0] dividend,
    input  logic        [pid_pkg::TICK_W-1:0] divisor,
    output logic                              busy,
    output logic signed [pid_pkg::DIFF_W-1:0] quotient
);

    logic                          busy_reg, busy_next;
    logic [pid_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [pid_pkg::MAG_W-1:0]     q_reg, q_next;
    logic [pid_pkg::TICK_W-1:0]    rem_reg, rem_next;
    logic [pid_pkg::TICK_W-1:0]    dvs_reg, dvs_next;
    logic                          neg_reg, neg_next;
    logic [pid_pkg::TICK_W:0]      rem_sh;
    logic [pid_pkg::TICK_W:0]      rem_sub;
    logic                          ge;
    logic signed [pid_pkg::DIFF_W-1:0] dividend_abs;

    // One quotient bit per cycle
    always_comb
    begin
        dividend_abs = dividend[pid_pkg::DIFF_W-1] ? -dividend : dividend;
        rem_sh  = {rem_reg, q_reg[pid_pkg::MAG_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = (rem_sh >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pid_pkg::CNT_W'(pid_pkg::MAG_W);
            q_next    = dividend_abs[pid_pkg::MAG_W-1:0];
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[pid_pkg::DIFF_W-1];
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[pid_pkg::MAG_W-2:0], ge};
            rem_next = ge ? rem_sub[pid_pkg::TICK_W-1:0] : rem_sh[pid_pkg::TICK_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pid_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Apply the sign of the dividend
    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

// ----- rtl/pid_dp.sv -----
// PID datapath: gains, controller state, shared multiplier and accumulators,
// output register. Driven by the control word from pid_seq; depends on pid_pkg.
module pid_dp (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      load,
    input  logic signed [pid_pkg::SAMPLE_WIDTH-1:0]   target_value,
    input  logic signed [pid_pkg::SAMPLE_WIDTH-1:0]   measured_value,
    input  logic        [pid_pkg::TICK_W-1:0]         elapsed_ticks,
    input  logic                                      cfg_we,
    input  logic        [pid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic        [pid_pkg::GAIN_W-1:0]         cfg_data,
    input  pid_pkg::dp_ctrl_t                         ctrl,
    input  logic signed [pid_pkg::DIFF_W-1:0]         quot,
    input  logic                                      out_stall,
    output logic signed [pid_pkg::DIFF_W-1:0]         dividend,
    output logic        [pid_pkg::TICK_W-1:0]         divisor,
    output logic                                      out_valid,
    output logic                                      out_full,
    output logic signed [pid_pkg::OUT_W-1:0]          drive_value
);

    localparam int IW  = pid_pkg::INTEGRAL_WIDTH;
    localparam int ISW = pid_pkg::INT_SUM_W;
    localparam int SW  = pid_pkg::SUM_W;

    localparam logic signed [ISW-1:0] I_MAX = $signed(ISW'({1'b0, {(IW-1){1'b1}}}));
    localparam logic signed [ISW-1:0] I_MIN = -I_MAX - 1;
    localparam logic signed [SW-1:0]  S_MAX =
        $signed(SW'({1'b0, {(pid_pkg::SAT_W-1){1'b1}}}));
    localparam logic signed [SW-1:0]  S_MIN = -S_MAX - 1;
    localparam logic signed [pid_pkg::SAT_W-1:0] O_MAX =
        $signed(pid_pkg::SAT_W'({1'b0, {(pid_pkg::OUT_W-1){1'b1}}}));
    localparam logic signed [pid_pkg::SAT_W-1:0] O_MIN = -O_MAX - 1;

    // Clamp a wide sum to the signed 64-bit range
    function automatic logic signed [pid_pkg::SAT_W-1:0] sat64(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] c;
        if (x > S_MAX)
            c = S_MAX;
        else if (x < S_MIN)
            c = S_MIN;
        else
            c = x;
        return $signed(c[pid_pkg::SAT_W-1:0]);
    endfunction

    logic signed [pid_pkg::GAIN_W-1:0]  prop_gain_reg, prop_gain_next;
    logic signed [pid_pkg::GAIN_W-1:0]  integ_gain_reg, integ_gain_next;
    logic signed [pid_pkg::GAIN_W-1:0]  deriv_gain_reg, deriv_gain_next;
    logic signed [IW-1:0]               integral_reg, integral_next;
    logic signed [pid_pkg::ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic                               out_valid_reg, out_valid_next;

    logic signed [pid_pkg::ERR_W-1:0]   err_reg, err_next;
    logic signed [pid_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic        [pid_pkg::TICK_W-1:0]  ticks_reg, ticks_next;
    logic signed [pid_pkg::MUL_W-1:0]   mul_reg, mul_next;
    logic signed [SW-1:0]               tmp_reg, tmp_next;
    logic signed [pid_pkg::SAT_W-1:0]   acc_reg, acc_next;
    logic signed [pid_pkg::OUT_W-1:0]   drive_value_reg, drive_value_next;

    logic signed [pid_pkg::MA_W-1:0]    a_op;
    logic signed [pid_pkg::MB_W-1:0]    b_op;
    logic signed [pid_pkg::MUL_W-1:0]   prod;
    logic signed [SW-1:0]               mul_ext;
    logic signed [ISW-1:0]              isum;
    logic signed [pid_pkg::SAT_W-1:0]   shifted;

    // Multiplier operand selection
    always_comb
    begin
        unique case (ctrl.a_sel)
            pid_pkg::A_TICKS: a_op = $signed({1'b0, ticks_reg});
            pid_pkg::A_PROP:  a_op = pid_pkg::MA_W'(prop_gain_reg);
            pid_pkg::A_INTEG: a_op = pid_pkg::MA_W'(integ_gain_reg);
            default:          a_op = pid_pkg::MA_W'(deriv_gain_reg);
        endcase
        unique case (ctrl.b_sel)
            pid_pkg::B_ERR:  b_op = pid_pkg::MB_W'(err_reg);
            pid_pkg::B_QUOT: b_op = pid_pkg::MB_W'(quot);
            pid_pkg::B_ILO:  b_op = $signed(pid_pkg::MB_W'(integral_reg[pid_pkg::LO_W-1:0]));
            default:         b_op = pid_pkg::MB_W'($signed(integral_reg[IW-1:pid_pkg::LO_W]));
        endcase
    end

    assign prod    = a_op * b_op;
    assign mul_ext = SW'(mul_reg);
    assign isum    = ISW'(integral_reg) + ISW'(mul_reg);
    assign shifted = acc_reg >>> pid_pkg::GAIN_FRAC_BITS;

    // Next values of all registers
    always_comb
    begin
        prop_gain_next   = prop_gain_reg;
        integ_gain_next  = integ_gain_reg;
        deriv_gain_next  = deriv_gain_reg;
        integral_next    = integral_reg;
        prev_err_next    = prev_err_reg;
        out_valid_next   = out_valid_reg;
        err_next         = err_reg;
        diff_next        = diff_reg;
        ticks_next       = ticks_reg;
        mul_next         = mul_reg;
        tmp_next         = tmp_reg;
        acc_next         = acc_reg;
        drive_value_next = drive_value_reg;

        // Gain writes; other indexes drop
        if (cfg_we)
        begin
            unique case (cfg_index)
                pid_pkg::REG_PROP_GAIN:  prop_gain_next  = $signed(cfg_data);
                pid_pkg::REG_INTEG_GAIN: integ_gain_next = $signed(cfg_data);
                pid_pkg::REG_DERIV_GAIN: deriv_gain_next = $signed(cfg_data);
                default: ;
            endcase
        end

        // Capture a new item: error, error difference and elapsed ticks
        if (load)
        begin
            err_next   = pid_pkg::ERR_W'(target_value) - pid_pkg::ERR_W'(measured_value);
            diff_next  = pid_pkg::DIFF_W'(err_next) - pid_pkg::DIFF_W'(prev_err_reg);
            ticks_next = elapsed_ticks;
        end

        if (ctrl.mul_en)
        begin
            mul_next = prod;
        end

        // Release the output register once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl.op)
            pid_pkg::OP_INTEG:
            begin
                if (isum > I_MAX)
                    integral_next = $signed(I_MAX[IW-1:0]);
                else if (isum < I_MIN)
                    integral_next = $signed(I_MIN[IW-1:0]);
                else
                    integral_next = $signed(isum[IW-1:0]);
                prev_err_next = err_reg;
            end
            pid_pkg::OP_TMP_LO:   tmp_next = mul_ext;
            pid_pkg::OP_TMP_HI:   tmp_next = tmp_reg + (mul_ext <<< pid_pkg::LO_W);
            pid_pkg::OP_ACC_LOAD: acc_next = sat64(mul_ext);
            pid_pkg::OP_ACC_MUL:  acc_next = sat64(SW'(acc_reg) + SW'(sat64(mul_ext)));
            pid_pkg::OP_ACC_TMP:  acc_next = sat64(SW'(acc_reg) + SW'(sat64(tmp_reg)));
            pid_pkg::OP_EMIT:
            begin
                if (shifted > O_MAX)
                    drive_value_next = $signed(O_MAX[pid_pkg::OUT_W-1:0]);
                else if (shifted < O_MIN)
                    drive_value_next = $signed(O_MIN[pid_pkg::OUT_W-1:0]);
                else
                    drive_value_next = $signed(shifted[pid_pkg::OUT_W-1:0]);
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Gains, controller state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            integral_reg   <= '0;
            prev_err_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prop_gain_reg  <= prop_gain_next;
            integ_gain_reg <= integ_gain_next;
            deriv_gain_reg <= deriv_gain_next;
            integral_reg   <= integral_next;
            prev_err_reg   <= prev_err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        err_reg         <= err_next;
        diff_reg        <= diff_next;
        ticks_reg       <= ticks_next;
        mul_reg         <= mul_next;
        tmp_reg         <= tmp_next;
        acc_reg         <= acc_next;
        drive_value_reg <= drive_value_next;
    end

    assign dividend    = diff_reg;
    assign divisor     = ticks_reg;
    assign out_valid   = out_valid_reg;
    assign out_full    = out_valid_reg & out_stall;
    assign drive_value = drive_value_reg;

endmodule

// ----- rtl/pid_controller_step.sv -----
// Parallel-form PID step. The derivative term comes from a bit-serial divider
// that runs one quotient bit per cycle. One item is in work at a time: a new
// item is stalled until the previous result is in the output register; an item
// with zero elapsed time is accepted but starts no program and gives no result.
// Reset (rst_n, async, active low) zeroes gains, integral and previous error.
module pid_controller_step (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [pid_pkg::SAMPLE_WIDTH-1:0]  target_value,
    input  logic signed [pid_pkg::SAMPLE_WIDTH-1:0]  measured_value,
    input  logic        [pid_pkg::TICK_W-1:0]        elapsed_ticks,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [pid_pkg::OUT_W-1:0]         drive_value,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic        [pid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic        [pid_pkg::GAIN_W-1:0]        cfg_data
);

    logic                               busy;
    logic                               load;
    logic                               start;
    logic                               div_start;
    logic                               div_busy;
    logic                               out_full;
    logic signed [pid_pkg::DIFF_W-1:0]  dividend;
    logic        [pid_pkg::TICK_W-1:0]  divisor;
    logic signed [pid_pkg::DIFF_W-1:0]  quot;
    pid_pkg::dp_ctrl_t                  ctrl;
    pid_pkg::seq_stat_t                 stat;

    // Take an item only between programs; zero elapsed time starts nothing
    assign in_stall   = busy;
    assign load       = in_valid & ~busy;
    assign start      = load & (elapsed_ticks != '0);
    assign cfg_ready  = 1'b1;
    assign stat.div_busy = div_busy;
    assign stat.out_full = out_full;

    pid_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .stat      (stat),
        .busy      (busy),
        .div_start (div_start),
        .ctrl      (ctrl)
    );

    pid_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quot)
    );

    pid_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .target_value   (target_value),
        .measured_value (measured_value),
        .elapsed_ticks  (elapsed_ticks),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ctrl           (ctrl),
        .quot           (quot),
        .out_stall      (out_stall),
        .dividend       (dividend),
        .divisor        (divisor),
        .out_valid      (out_valid),
        .out_full       (out_full),
        .drive_value    (drive_value)
    );

endmodule
